@@ src/lfsa_pkg.sv @@
`default_nettype none

package lfsa_pkg;

  localparam int unsigned SLOTS       = 64;
  localparam int unsigned TIME_BITS   = 32;
  localparam int unsigned SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned IN_TIME_W   = 32;
  localparam int unsigned GUEST_W     = 16;
  localparam int unsigned OUT_SLOT_W  = 6;

  typedef logic [TIME_BITS-1:0]  time_t;
  typedef logic [SLOT_W-1:0]     slot_t;
  typedef logic [GUEST_W-1:0]    guest_t;
  typedef logic [OUT_SLOT_W-1:0] out_slot_t;

  // Guest as it travels down the row of slot cells
  typedef struct packed {
    time_t arrival;
    time_t departure;
    logic  granted;
    slot_t slot;
    logic  is_target;
  } item_t;

  // Fit a port time to the internal time width: truncate or zero-extend
  function automatic time_t to_time(input logic [IN_TIME_W-1:0] v);
    time_t r;
    r = '0;
    for (int unsigned i = 0; i < TIME_BITS; i++) begin
      if (i < IN_TIME_W) begin
        r[i] = v[i];
      end
    end
    return r;
  endfunction

  // Fit a slot index to the result field: truncate or zero-extend
  function automatic out_slot_t to_out_slot(input slot_t s);
    out_slot_t r;
    r = '0;
    for (int unsigned i = 0; i < OUT_SLOT_W; i++) begin
      if (i < SLOT_W) begin
        r[i] = s[i];
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ src/lfsa_cell.sv @@
`default_nettype none

module lfsa_cell (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            advance_i,
  input  wire lfsa_pkg::slot_t slot_idx_i,
  input  wire logic            valid_i,
  input  wire lfsa_pkg::item_t item_i,
  output logic                 valid_o,
  output lfsa_pkg::item_t      item_o
);
  import lfsa_pkg::*;

  logic  busy_q, busy_d;
  time_t dep_q;
  logic  valid_q;
  item_t item_q, item_d;
  logic  freed, busy_now, take, step;

  // free on departure at or before arrival, then claim if no lower cell did
  assign step     = advance_i && valid_i;
  assign freed    = busy_q && (dep_q <= item_i.arrival);
  assign busy_now = busy_q && !freed;
  assign take     = valid_i && !item_i.granted && !busy_now;

  always_comb begin
    busy_d = busy_now || take;
    item_d = item_i;
    if (take) begin
      item_d.granted = 1'b1;
      item_d.slot    = slot_idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      valid_q <= 1'b0;
    end else if (advance_i) begin
      valid_q <= valid_i;
      if (step) begin
        busy_q <= busy_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      item_q <= item_d;
      if (step && take) begin
        dep_q <= item_i.departure;
      end
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

@@ src/lowest_free_slot_timed_allocator.sv @@
// Lowest-free-slot allocator for guests presented in arrival order.
//
// Input channel (in_valid_i / in_ready_o): one guest per transfer with
// arrival time, departure time and guest id. Output channel (out_valid_o /
// out_ready_i): one result per guest, in guest order: the slot given, a
// flag for the configured target guest, and a flag when every slot was busy
// (then slot_number_o is 0 and nothing is allocated).
// cfg_we_i / cfg_wdata_i write the target guest id; write only while idle.
//
// Each slot is one cell in a row. A guest walks the row one cell per cycle
// while the row advances; each cell frees itself if its stored departure is
// at or before the arrival, then claims the guest if no lower cell did. A
// guest passes the cells in order, then the result register; throughput is
// one guest per cycle while the row advances.
//
// Reset frees every slot and clears the target id to 0; no clearing pass.
// When the receiver stalls, the result register holds and the row keeps
// advancing until its last cell holds a guest, so input is taken meanwhile.
`default_nettype none

module lowest_free_slot_timed_allocator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] arrival_time_i,
  input  wire logic [31:0] departure_time_i,
  input  wire logic [15:0] guest_id_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [5:0]       slot_number_o,
  output logic             is_target_o,
  output logic             no_free_slot_o
);
  import lfsa_pkg::*;

  guest_t    target_q;
  logic      advance;
  logic      out_load;
  logic      chain_valid [SLOTS+1];
  item_t     chain_item  [SLOTS+1];

  logic      out_valid_q;
  out_slot_t slot_q;
  logic      is_target_q;
  logic      no_free_q;

  // hold the target id; the user must write it only while the block is idle, the block itself does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
    end else if (cfg_we_i) begin
      target_q <= cfg_wdata_i;
    end
  end

  // load the result register when it is empty or its result leaves
  assign out_load   = !out_valid_q || out_ready_i;
  // advance the row unless its last cell holds a result that cannot leave
  assign advance    = out_load || !chain_valid[SLOTS];
  assign in_ready_o = advance;

  // entry: fit times, compare id against the target once at the front
  always_comb begin
    chain_valid[0]          = in_valid_i;
    chain_item[0].arrival   = to_time(arrival_time_i);
    chain_item[0].departure = to_time(departure_time_i);
    chain_item[0].granted   = 1'b0;
    chain_item[0].slot      = '0;
    chain_item[0].is_target = (guest_id_i == target_q);
  end

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    lfsa_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .advance_i  (advance),
      .slot_idx_i (SLOT_W'(g)),
      .valid_i    (chain_valid[g]),
      .item_i     (chain_item[g]),
      .valid_o    (chain_valid[g+1]),
      .item_o     (chain_item[g+1])
    );
  end

  // result register: hold while stalled, else take whatever the last cell shows
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= chain_valid[SLOTS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      slot_q      <= chain_item[SLOTS].granted ? to_out_slot(chain_item[SLOTS].slot) : '0;
      is_target_q <= chain_item[SLOTS].is_target;
      no_free_q   <= !chain_item[SLOTS].granted;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign slot_number_o  = slot_q;
  assign is_target_o    = is_target_q;
  assign no_free_slot_o = no_free_q;

endmodule

`default_nettype wire

@@ src/lfsa_checker.sv @@
`default_nettype none

module lfsa_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [5:0] slot_number_o,
  input wire logic       is_target_o,
  input wire logic       no_free_slot_o
);

  // a stalled result stays shown
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its fields
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(slot_number_o) && $stable(is_target_o) && $stable(no_free_slot_o))
    else $error("result changed while stalled");

  // a full block reports slot 0
  a_full_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && no_free_slot_o |-> slot_number_o == 6'd0)
    else $error("slot number set with no free slot");

  // input is taken whenever the output side can drain
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o || out_ready_i |-> in_ready_o)
    else $error("input held off with output free");

endmodule

bind lowest_free_slot_timed_allocator lfsa_checker u_lfsa_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .slot_number_o  (slot_number_o),
  .is_target_o    (is_target_o),
  .no_free_slot_o (no_free_slot_o)
);

`default_nettype wire

@@ verif/lowest_free_slot_timed_allocator_tb.sv @@
`timescale 1ns / 100ps

module lowest_free_slot_timed_allocator_tb;

  localparam int unsigned N_SLOTS         = lfsa_pkg::SLOTS;
  // Guest walks one cell per cycle while the row advances, plus the result register
  localparam int unsigned LATENCY         = N_SLOTS + 1;
  localparam int unsigned PHASES          = 6;
  localparam int unsigned ITEMS_PER_PHASE = 325;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned IDLE_PCT        = 17;

  typedef enum int unsigned {
    REGIME_STEADY,
    REGIME_CROWD,
    REGIME_NOISE
  } regime_e;

  // One seating decision as the block reports it
  typedef struct {
    lfsa_pkg::out_slot_t slot_number;
    logic                is_target;
    logic                no_free_slot;
  } seat_t;

  // One row of the directed table; typed rows carry a hand-written answer
  typedef struct {
    lfsa_pkg::time_t  arrival;
    lfsa_pkg::time_t  departure;
    lfsa_pkg::guest_t guest;
    bit               typed;
    seat_t            answer;
  } guest_row_t;

  logic        clk_i            = 1'b0;
  logic        rst_ni           = 1'b0;
  logic        cfg_we_i         = 1'b0;
  logic [15:0] cfg_wdata_i      = '0;
  logic        in_valid_i       = 1'b0;
  logic        in_ready_o;
  logic [31:0] arrival_time_i   = '0;
  logic [31:0] departure_time_i = '0;
  logic [15:0] guest_id_i       = '0;
  logic        out_valid_o;
  logic        out_ready_i      = 1'b0;
  logic [5:0]  slot_number_o;
  logic        is_target_o;
  logic        no_free_slot_o;

  lowest_free_slot_timed_allocator u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .arrival_time_i   (arrival_time_i),
    .departure_time_i (departure_time_i),
    .guest_id_i       (guest_id_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .slot_number_o    (slot_number_o),
    .is_target_o      (is_target_o),
    .no_free_slot_o   (no_free_slot_o)
  );

  // Shadow of the chair row: which chairs are taken and when each frees up
  bit               chair_taken [N_SLOTS];
  lfsa_pkg::time_t  chair_leaves[N_SLOTS];
  lfsa_pkg::guest_t watched_guest = '0;

  seat_t       pending_seats[$];
  guest_row_t  directed_rows[$];
  int unsigned fail_count = 0;
  bit          calm       = 1'b0;   // suppress idling on both sides

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Free every chair whose guest has left by this arrival, then give the
  // lowest free chair to the new guest. No free chair: allocate nothing.
  function automatic seat_t seat_guest(input lfsa_pkg::time_t arrival,
                                       input lfsa_pkg::time_t departure,
                                       input lfsa_pkg::guest_t guest);
    seat_t       s;
    bit          found;
    int unsigned pick;
    found = 1'b0;
    pick  = 0;
    for (int unsigned i = 0; i < N_SLOTS; i++) begin
      if (chair_taken[i] && chair_leaves[i] <= arrival) begin
        chair_taken[i] = 1'b0;
      end
    end
    for (int unsigned i = 0; i < N_SLOTS; i++) begin
      if (!found && !chair_taken[i]) begin
        found = 1'b1;
        pick  = i;
      end
    end
    if (found) begin
      chair_taken[pick]  = 1'b1;
      chair_leaves[pick] = departure;
    end
    s.slot_number  = found ? lfsa_pkg::out_slot_t'(pick) : '0;
    s.is_target    = (guest == watched_guest);
    s.no_free_slot = !found;
    return s;
  endfunction

  // Offer one guest and hold it until the transfer. Valid stays high into
  // the next call, so back-to-back guests need no gap. On the transfer,
  // predict the seat and queue it (or the typed answer, where given).
  task automatic offer_guest(input lfsa_pkg::time_t arrival,
                             input lfsa_pkg::time_t departure,
                             input lfsa_pkg::guest_t guest,
                             input bit typed, input seat_t answer);
    seat_t predicted;
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    arrival_time_i   <= arrival;
    departure_time_i <= departure;
    guest_id_i       <= guest;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted = seat_guest(arrival, departure, guest);
    pending_seats.push_back(typed ? answer : predicted);
  endtask

  // Drop valid and wait for every queued seat to come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_seats.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Register write while the row is empty; mirror it in the shadow
  task automatic set_watched_guest(input lfsa_pkg::guest_t value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i      <= 1'b0;
    watched_guest  = value;
  endtask

  task automatic add_row(input lfsa_pkg::time_t arrival,
                         input lfsa_pkg::time_t departure,
                         input lfsa_pkg::guest_t guest, input bit typed,
                         input int unsigned slot, input bit tgt, input bit full);
    guest_row_t r;
    r.arrival             = arrival;
    r.departure           = departure;
    r.guest               = guest;
    r.typed               = typed;
    r.answer.slot_number  = lfsa_pkg::out_slot_t'(slot);
    r.answer.is_target    = tgt;
    r.answer.no_free_slot = full;
    directed_rows.push_back(r);
  endtask

  // Result side: check each transfer against the oldest expected seat, and
  // stall at random. Twice, hold off for a long stretch while the sender
  // keeps offering, so the row fills and in_ready_o drops.
  initial begin : result_side
    seat_t       want;
    int unsigned taken;
    int unsigned held_at;
    taken   = 0;
    held_at = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        taken++;
        if (pending_seats.size() == 0) begin
          fail_count++;
          $display("%0t: result with nothing expected: slot %0d target %0b full %0b",
                   $time, slot_number_o, is_target_o, no_free_slot_o);
        end else begin
          want = pending_seats.pop_front();
          if (slot_number_o !== want.slot_number) begin
            fail_count++;
            $display("%0t: slot_number expected %0d actual %0d",
                     $time, want.slot_number, slot_number_o);
          end
          if (is_target_o !== want.is_target) begin
            fail_count++;
            $display("%0t: is_target expected %0b actual %0b",
                     $time, want.is_target, is_target_o);
          end
          if (no_free_slot_o !== want.no_free_slot) begin
            fail_count++;
            $display("%0t: no_free_slot expected %0b actual %0b",
                     $time, want.no_free_slot, no_free_slot_o);
          end
        end
      end
      if ((taken == 40 || taken == 1100) && held_at != taken) begin
        held_at      = taken;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_ready_i <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : guest_side
    regime_e          regime;
    int unsigned      run_left;
    int unsigned      pick;
    lfsa_pkg::time_t  clock_now;
    lfsa_pkg::time_t  arrival;
    lfsa_pkg::time_t  departure;
    lfsa_pkg::guest_t guest;
    lfsa_pkg::guest_t target;
    seat_t            no_answer;

    no_answer = '{default: '0};
    for (int unsigned i = 0; i < N_SLOTS; i++) begin
      chair_taken[i]  = 1'b0;
      chair_leaves[i] = '0;
    end

    // Directed guests, target id at its reset value of 0
    add_row(32'd0,          32'd10,         16'h0000, 1'b1, 0, 1'b1, 1'b0);
    add_row(32'd0,          32'hFFFF_FFFF,  16'hFFFF, 1'b1, 1, 1'b0, 1'b0);
    add_row(32'd5,          32'd5,          16'h0001, 1'b1, 2, 1'b0, 1'b0);
    // departure before arrival: still seated, freed by the next guest
    add_row(32'd5,          32'd3,          16'h0002, 1'b0, 0, 1'b0, 1'b0);
    add_row(32'd6,          32'd6,          16'h0003, 1'b0, 0, 1'b0, 1'b0);
    add_row(32'd10,         32'd20,         16'h0000, 1'b0, 0, 1'b0, 1'b0);
    // arrival out of order
    add_row(32'd4,          32'd100,        16'h0004, 1'b0, 0, 1'b0, 1'b0);
    add_row(32'd12,         32'd0,          16'h8000, 1'b0, 0, 1'b0, 1'b0);
    add_row(32'h7FFF_FFFF,  32'h8000_0000,  16'h7FFF, 1'b0, 0, 1'b0, 1'b0);
    // latest possible arrival frees every chair
    add_row(32'hFFFF_FFFF,  32'hFFFF_FFFF,  16'hAAAA, 1'b1, 0, 1'b0, 1'b0);
    add_row(32'hFFFF_FFFF,  32'd0,          16'h5555, 1'b1, 0, 1'b0, 1'b0);
    add_row(32'd0,          32'd1,          16'h0000, 1'b0, 0, 1'b0, 1'b0);
    add_row(32'd1,          32'd1,          16'h0000, 1'b0, 0, 1'b0, 1'b0);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      offer_guest(directed_rows[i].arrival, directed_rows[i].departure,
                  directed_rows[i].guest, directed_rows[i].typed,
                  directed_rows[i].answer);
    end
    wait_drained();

    // Random phases, each with its own target id. Most guests form an
    // ordered stream: steady traffic keeps the row near full, crowds pile
    // up faster than anyone leaves so every chair gets taken. Noise guests
    // carry arbitrary times and break the ordering.
    for (int unsigned p = 0; p < PHASES; p++) begin
      case (p)
        0:       target = 16'hFFFF;
        1:       target = 16'h0000;
        3:       target = 16'h8000;
        5:       target = 16'h0001;
        default: target = lfsa_pkg::guest_t'($urandom_range(0, 65535));
      endcase
      set_watched_guest(target);
      calm = (p == 1);
      // phase 3 starts near the top of the time range so arrivals wrap
      clock_now = (p == 3) ? 32'hFFFF_FE00 : lfsa_pkg::time_t'($urandom_range(0, 1000));
      run_left  = 0;
      regime    = REGIME_STEADY;

      for (int unsigned k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (run_left == 0) begin
          pick     = $urandom_range(99);
          regime   = (pick < 45) ? REGIME_STEADY : (pick < 85) ? REGIME_CROWD : REGIME_NOISE;
          run_left = (regime == REGIME_CROWD) ? $urandom_range(70, 120)
                                              : $urandom_range(20, 60);
        end
        run_left--;
        guest = ($urandom_range(7) == 0) ? watched_guest
                                         : lfsa_pkg::guest_t'($urandom_range(0, 65535));
        case (regime)
          REGIME_STEADY: begin
            clock_now = clock_now + $urandom_range(0, 8);
            arrival   = clock_now;
            departure = ($urandom_range(15) == 0) ? clock_now - $urandom_range(0, 50)
                                                  : clock_now + $urandom_range(0, 400);
          end
          REGIME_CROWD: begin
            clock_now = clock_now + $urandom_range(0, 1);
            arrival   = clock_now;
            departure = clock_now + $urandom_range(300, 4000);
          end
          default: begin
            arrival   = $urandom();
            departure = $urandom();
          end
        endcase
        offer_guest(arrival, departure, guest, 1'b0, no_answer);
      end
      wait_drained();
    end
    calm = 1'b0;

    // Let any stray result show up before the verdict
    repeat (LATENCY) @(posedge clk_i);
    if (fail_count == 0 && pending_seats.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
